### rtl/dsfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfd_pkg
// Shared symbols, CRC polynomial and frame report codes for the DLE frame
// decoder.
// ----------------------------------------------------------------------------
package dsfd_pkg;

	localparam logic [7:0]  SYM_SOH  = 8'h01;
	localparam logic [7:0]  SYM_EOT  = 8'h04;
	localparam logic [7:0]  SYM_DLE  = 8'h10;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [2:0] {
		ST_GOOD    = 3'd0,
		ST_BAD_CRC = 3'd1,
		ST_SHORT   = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_ABORT   = 3'd4
	} frame_status_t;

	typedef enum logic [0:0] {
		KIND_PAYLOAD = 1'b0,
		KIND_REPORT  = 1'b1
	} out_kind_t;

endpackage
`default_nettype wire

### rtl/dsfd_crc16.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfd_crc16
// Byte-wide CRC-16/XMODEM update, MSB first, no reflection.
// ----------------------------------------------------------------------------
module dsfd_crc16 (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ dsfd_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

### rtl/dsfd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfd_core
// Frame state, byte hold-back, CRC check and result register.
// ----------------------------------------------------------------------------
module dsfd_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic [7:0] item_byte,
	output logic            item_take,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            out_kind,
	output logic [7:0]      payload_byte,
	output logic [2:0]      frame_status,
	output logic            frame_last
);

	logic        escape_q;
	logic [1:0]  count_q;
	logic [7:0]  newer_q;
	logic [7:0]  older_q;
	logic [15:0] crc_q;
	logic [15:0] crc_fed;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  byte_q;
	logic [2:0]  status_q;
	logic        last_q;

	logic        is_dle;
	logic        is_soh;
	logic        is_eot;
	logic        res_valid;
	logic        res_kind;
	logic [7:0]  res_byte;
	dsfd_pkg::frame_status_t res_status;

	dsfd_crc16 u_crc (
		.crc_in  (crc_q),
		.data    (older_q),
		.crc_out (crc_fed)
	);

	assign item_take = item_valid && (!out_valid_q || out_ready);

	assign is_dle = !escape_q && (item_byte == dsfd_pkg::SYM_DLE);
	assign is_soh = !escape_q && (item_byte == dsfd_pkg::SYM_SOH);
	assign is_eot = !escape_q && (item_byte == dsfd_pkg::SYM_EOT);

	always_comb begin
		res_valid  = 1'b0;
		res_kind   = dsfd_pkg::KIND_PAYLOAD;
		res_byte   = 8'h00;
		res_status = dsfd_pkg::ST_GOOD;
		if (is_dle) begin
			res_valid = 1'b0;
		end else if (is_soh) begin
			res_valid  = (count_q != 2'd0);
			res_kind   = dsfd_pkg::KIND_REPORT;
			res_status = dsfd_pkg::ST_ABORT;
		end else if (is_eot) begin
			res_valid = 1'b1;
			res_kind  = dsfd_pkg::KIND_REPORT;
			if (count_q < 2'd2) begin
				res_status = dsfd_pkg::ST_SHORT;
			end else if ({newer_q, older_q} != crc_q) begin
				res_status = dsfd_pkg::ST_BAD_CRC;
			end else if (count_q == 2'd2) begin
				res_status = dsfd_pkg::ST_EMPTY;
			end else begin
				res_status = dsfd_pkg::ST_GOOD;
			end
		end else begin
			res_valid = (count_q >= 2'd2);
			res_byte  = older_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			count_q  <= 2'd0;
			newer_q  <= 8'h00;
			older_q  <= 8'h00;
			crc_q    <= 16'h0000;
		end else if (item_take) begin
			if (is_dle) begin
				escape_q <= 1'b1;
			end else if (is_soh || is_eot) begin
				escape_q <= 1'b0;
				count_q  <= 2'd0;
				newer_q  <= 8'h00;
				older_q  <= 8'h00;
				crc_q    <= 16'h0000;
			end else begin
				escape_q <= 1'b0;
				if (count_q >= 2'd2) begin
					crc_q <= crc_fed;
				end
				older_q <= newer_q;
				newer_q <= item_byte;
				if (count_q != 2'd3) begin
					count_q <= count_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && res_valid) begin
			kind_q   <= res_kind;
			byte_q   <= res_byte;
			status_q <= res_status;
			last_q   <= res_kind;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = kind_q;
	assign payload_byte = byte_q;
	assign frame_status = status_q;
	assign frame_last   = last_q;

endmodule
`default_nettype wire

### rtl/dle_stuffed_frame_decoder_crc16_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dle_stuffed_frame_decoder_crc16_top
// DLE byte-stuffed frame decoder with CRC-16/XMODEM check.
// ----------------------------------------------------------------------------
// Takes one link byte per transfer and sustains one byte per cycle. A byte
// is held in the input register; when the core takes it, the decoder updates
// escape, hold-back and CRC state in a single pass and loads the result
// register. Most bytes give no result or one payload byte; the end of a
// frame gives a status report with frame_last set. Back-pressure on the
// output stalls the input only while a result waits and the input register
// is full.
// ----------------------------------------------------------------------------
module dle_stuffed_frame_decoder_crc16_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            out_kind,
	output logic [7:0]      payload_byte,
	output logic [2:0]      frame_status,
	output logic            frame_last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	dsfd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.item_byte    (byte_s1),
		.item_take    (take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.payload_byte (payload_byte),
		.frame_status (frame_status),
		.frame_last   (frame_last)
	);

endmodule
`default_nettype wire
